// ----- rtl/core/mie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, constants and the quarter-wave sine generator for the modal
// impact excitation block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int MAX_MODES_DEF  = 16;
    localparam int SINE_BITS_DEF  = 10;
    localparam int WALK_CAP       = 16;
    localparam int AMP_LIMIT      = 20480;

    // field widths
    localparam int IDX_W    = 4;
    localparam int ORD_W    = 4;
    localparam int GAIN_W   = 16;
    localparam int PT_W     = 16;
    localparam int AMP_W    = 16;
    localparam int EN_W     = 19;
    localparam int CNT_W    = 5;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 19;
    localparam int COORD_W  = 17;
    localparam int SHAPE_W  = 15;

    // input item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_IMPACT = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_DIM_X,
        CFG_DIM_Y,
        CFG_DIM_Z,
        CFG_EXCITE_GAIN,
        CFG_MODE_COUNT,
        CFG_ENERGY_FLOOR
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_EMPTY,
        S_LD_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_LD_RES,
        S_M_RD,
        S_M_LAT,
        S_A_IDX,
        S_A_SHP,
        S_MUL_GS,
        S_MUL_P,
        S_MUL_Q,
        S_ACC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic             load_wr;
        logic             rd;
        logic             sum_acc;
        logic             lat;
        logic             idx_calc;
        logic             shp_step;
        logic             mul_gs;
        logic             mul_p;
        logic             mul_q;
        logic             acc_upd;
        logic             res_empty;
        logic             res_load;
        logic             last;
        logic [1:0]       axis;
        logic [CNT_W-1:0] index;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] walk_n;
        logic             out_free;
    } t_stat;

    // sin(pi/2 * x), x in Q0.16 (0..65536), result Q1.14 capped at 16384
    function automatic logic [SHAPE_W-1:0] quarter_sine(input logic [COORD_W-1:0] x);
        logic [63:0] xx;
        logic [63:0] y;
        logic [63:0] p;
        logic [63:0] r;
        xx = 64'(x);
        y  = (xx * xx) >> 2;
        p  = 64'd172273;
        p  = 64'd5026995 - ((p * y) >> 30);
        p  = 64'd85569306 - ((p * y) >> 30);
        p  = 64'd693598669 - ((p * y) >> 30);
        p  = 64'd1686629713 - ((p * y) >> 30);
        r  = (p * xx + (64'd1 << 31)) >> 32;
        return (r > 64'd16384) ? SHAPE_W'(16384) : r[SHAPE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/mie_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mie_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mie_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer: coordinate divisions, load energy walk and per-mode update steps.
// ----------------------------------------------------------------------------
module mie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  mie_pkg::t_stat i_stat,
    output mie_pkg::t_cmd  o_cmd
);

    import mie_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i;
    logic [1:0]       r_axis, n_axis;
    logic [4:0]       r_bit, n_bit;
    logic             w_last;

    assign w_last = ((r_i + CNT_W'(1)) == i_stat.walk_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_axis  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_axis  <= n_axis;
            r_bit   <= n_bit;
        end
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_axis  = r_axis;
        n_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_i    = '0;
                    n_axis = '0;
                    n_state = (i_in_kind == KIND_LOAD) ? S_LD_WR : S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                n_bit   = 5'd31;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_bit == 5'd0) begin
                    if (r_axis == 2'd2) begin
                        n_i     = '0;
                        n_state = (i_stat.walk_n == '0) ? S_EMPTY : S_M_RD;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_DIV_INIT;
                    end
                end else begin
                    n_bit = r_bit - 5'd1;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_LD_WR: begin
                n_i     = '0;
                n_state = (i_stat.walk_n == '0) ? S_LD_RES : S_SUM_RD;
            end
            S_SUM_RD: n_state = S_SUM_ACC;
            S_SUM_ACC: begin
                if (w_last) begin
                    n_state = S_LD_RES;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SUM_RD;
                end
            end
            S_LD_RES: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_M_RD: begin
                n_axis  = '0;
                n_state = S_M_LAT;
            end
            S_M_LAT: n_state = S_A_IDX;
            S_A_IDX: n_state = S_A_SHP;
            S_A_SHP: begin
                if (r_axis == 2'd2) begin
                    n_state = S_MUL_GS;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_A_IDX;
                end
            end
            S_MUL_GS: n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_Q;
            S_MUL_Q:  n_state = S_ACC;
            S_ACC: begin
                if (i_stat.out_free) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_M_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_cmd.index = r_i;
        o_cmd.last  = w_last;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_store = (r_bit == 5'd0);
            end
            S_EMPTY:   o_cmd.res_empty = i_stat.out_free;
            S_LD_WR:   o_cmd.load_wr   = 1'b1;
            S_SUM_RD:  o_cmd.rd        = 1'b1;
            S_SUM_ACC: o_cmd.sum_acc   = 1'b1;
            S_LD_RES:  o_cmd.res_load  = i_stat.out_free;
            S_M_RD:    o_cmd.rd        = 1'b1;
            S_M_LAT:   o_cmd.lat       = 1'b1;
            S_A_IDX:   o_cmd.idx_calc  = 1'b1;
            S_A_SHP:   o_cmd.shp_step  = 1'b1;
            S_MUL_GS:  o_cmd.mul_gs    = 1'b1;
            S_MUL_P:   o_cmd.mul_p     = 1'b1;
            S_MUL_Q:   o_cmd.mul_q     = 1'b1;
            S_ACC:     o_cmd.acc_upd   = i_stat.out_free;
            default:   o_cmd           = '0;
        endcase
    end

endmodule

// ----- rtl/core/mie_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_dp
// Datapath: config registers, mode tables, coordinate divider, sine lookup,
// gain multiplier chain, amplitude update and result register.
// ----------------------------------------------------------------------------
module mie_dp #(
    parameter int MAX_MODES       = mie_pkg::MAX_MODES_DEF,
    parameter int SINE_TABLE_BITS = mie_pkg::SINE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [mie_pkg::CFG_A_W-1:0]            i_cfg_addr,
    input  logic [mie_pkg::CFG_D_W-1:0]            i_cfg_data,
    // request fields
    input  logic [mie_pkg::IDX_W-1:0]              i_mode_index,
    input  logic [3*mie_pkg::ORD_W-1:0]            i_orders,
    input  logic [mie_pkg::GAIN_W-1:0]             i_mode_gain,
    input  logic [15:0]                            i_impulse,
    input  logic [mie_pkg::PT_W-1:0]               i_point_x,
    input  logic [mie_pkg::PT_W-1:0]               i_point_y,
    input  logic [mie_pkg::PT_W-1:0]               i_point_z,
    // control
    input  mie_pkg::t_cmd                          i_cmd,
    output mie_pkg::t_stat                         o_stat,
    // result register
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [mie_pkg::IDX_W-1:0]              o_entry,
    output logic [mie_pkg::AMP_W-1:0]              o_amplitude,
    output logic                                   o_saturated,
    output logic [mie_pkg::EN_W-1:0]               o_energy,
    output logic                                   o_silent,
    output logic                                   o_last
);

    import mie_pkg::*;

    localparam int IW       = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int WALK_MAX = (MAX_MODES < WALK_CAP) ? MAX_MODES : WALK_CAP;
    localparam int SB       = SINE_TABLE_BITS;
    localparam int QB       = SB - 2;
    localparam int QN       = 1 << QB;
    localparam logic [20:0] HALF = 21'(1 << (16 - SB));
    localparam logic signed [28:0] LIM_P = 29'(AMP_LIMIT);
    localparam logic signed [28:0] LIM_N = -LIM_P;

    // configuration registers
    logic [15:0]       r_dim_x, r_dim_y, r_dim_z, r_excite_gain;
    logic [CNT_W-1:0]  r_mode_count;
    logic [EN_W-1:0]   r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x       <= 16'd256;
            r_dim_y       <= 16'd256;
            r_dim_z       <= 16'd256;
            r_excite_gain <= 16'd4096;
            r_mode_count  <= '0;
            r_floor       <= EN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DIM_X:        r_dim_x       <= i_cfg_data[15:0];
                CFG_DIM_Y:        r_dim_y       <= i_cfg_data[15:0];
                CFG_DIM_Z:        r_dim_z       <= i_cfg_data[15:0];
                CFG_EXCITE_GAIN:  r_excite_gain <= i_cfg_data[15:0];
                CFG_MODE_COUNT:   r_mode_count  <= i_cfg_data[CNT_W-1:0];
                CFG_ENERGY_FLOOR: r_floor       <= i_cfg_data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stat.walk_n = (r_mode_count > CNT_W'(WALK_MAX)) ? CNT_W'(WALK_MAX)
                                                             : r_mode_count;

    // captured request
    logic [IDX_W-1:0]   r_mode_index;
    logic [3*ORD_W-1:0] r_ord_in;
    logic [GAIN_W-1:0]  r_gain_in;
    logic [31:0]        r_p1;
    logic [PT_W-1:0]    r_pt [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode_index <= i_mode_index;
            r_ord_in     <= i_orders;
            r_gain_in    <= i_mode_gain;
            r_p1         <= 32'(i_impulse) * 32'(r_excite_gain);
            r_pt[0]      <= i_point_x;
            r_pt[1]      <= i_point_y;
            r_pt[2]      <= i_point_z;
        end
    end

    // restoring divider for (|point| << 16) / dim, one quotient bit a cycle
    logic [15:0]        w_dim;
    logic [PT_W-1:0]    w_pt;
    logic               w_pt_neg;
    logic [15:0]        w_mag;
    logic [31:0]        r_dvd, r_quo, w_quo_next;
    logic [15:0]        r_rem;
    logic               r_neg;
    logic [16:0]        w_trial;
    logic               w_ge;
    logic               w_big;
    logic [COORD_W-1:0] w_coord;
    logic [COORD_W-1:0] r_cu [3];

    always_comb begin
        case (i_cmd.axis)
            2'd0:    w_dim = r_dim_x;
            2'd1:    w_dim = r_dim_y;
            default: w_dim = r_dim_z;
        endcase
    end

    assign w_pt       = r_pt[i_cmd.axis];
    assign w_pt_neg   = w_pt[PT_W-1];
    assign w_mag      = w_pt_neg ? 16'(17'h10000 - {1'b0, w_pt}) : w_pt;
    assign w_trial    = {r_rem, r_dvd[31]};
    assign w_ge       = (w_trial >= {1'b0, w_dim});
    assign w_quo_next = {r_quo[30:0], w_ge};
    assign w_big      = (w_quo_next >= 32'd32768);

    always_comb begin
        if (w_dim == 16'd0) begin
            w_coord = COORD_W'(32768);
        end else if (r_neg) begin
            w_coord = w_big ? '0 : (COORD_W'(32768) - COORD_W'(w_quo_next));
        end else begin
            w_coord = w_big ? COORD_W'(65536) : (COORD_W'(32768) + COORD_W'(w_quo_next));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dvd <= {w_mag, 16'h0000};
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= w_pt_neg;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= w_ge ? 16'(w_trial - {1'b0, w_dim}) : w_trial[15:0];
            r_quo <= w_quo_next;
        end
        if (i_cmd.div_store) begin
            r_cu[i_cmd.axis] <= w_coord;
        end
    end

    // mode tables
    logic [IW-1:0]      w_raddr, w_waddr;
    logic               w_tab_we, w_amp_we;
    logic [AMP_W-1:0]   w_amp_wdata;
    logic [3*ORD_W-1:0] w_ord_q;
    logic [GAIN_W-1:0]  w_gain_q;
    logic [AMP_W-1:0]   w_amp_q;
    logic               w_ld_ok;
    logic [MAX_MODES-1:0] r_vld;
    logic               r_rd_vld;

    logic signed [AMP_W-1:0] w_amp_new;

    assign w_ld_ok     = (32'(r_mode_index) < MAX_MODES);
    assign w_raddr     = IW'(i_cmd.index);
    assign w_waddr     = i_cmd.load_wr ? IW'(r_mode_index) : IW'(i_cmd.index);
    assign w_tab_we    = i_cmd.load_wr && w_ld_ok;
    assign w_amp_we    = w_tab_we || i_cmd.acc_upd;
    assign w_amp_wdata = i_cmd.load_wr ? '0 : w_amp_new;

    mie_ram #(.WIDTH(3*ORD_W), .DEPTH(MAX_MODES)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_waddr),
        .i_wdata (r_ord_in),
        .i_raddr (w_raddr),
        .o_rdata (w_ord_q)
    );

    mie_ram #(.WIDTH(GAIN_W), .DEPTH(MAX_MODES)) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_waddr),
        .i_wdata (r_gain_in),
        .i_raddr (w_raddr),
        .o_rdata (w_gain_q)
    );

    mie_ram #(.WIDTH(AMP_W), .DEPTH(MAX_MODES)) u_amp_ram (
        .i_clk   (i_clk),
        .i_we    (w_amp_we),
        .i_waddr (w_waddr),
        .i_wdata (w_amp_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_amp_q)
    );

    // amplitude valid bits: unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_amp_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd_vld <= r_vld[w_raddr];
    end

    logic signed [AMP_W-1:0] w_rd_amp;
    logic [EN_W-1:0]         w_rd_abs;

    assign w_rd_amp = r_rd_vld ? $signed(w_amp_q) : '0;
    assign w_rd_abs = w_rd_amp[AMP_W-1] ? EN_W'(-w_rd_amp) : EN_W'(w_rd_amp);

    // per-mode latch and shape product
    logic [3*ORD_W-1:0]      r_ord;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [AMP_W-1:0] r_amp;
    logic [SHAPE_W-1:0]      r_shape;
    logic                    r_sneg;
    logic [SB-1:0]           r_sidx;
    logic                    r_sen;
    logic [ORD_W-1:0]        w_ordn;
    logic [20:0]             w_tsum;

    logic [SHAPE_W-1:0] w_rom [QN+1];

    for (genvar g = 0; g <= QN; g++) begin : g_rom
        assign w_rom[g] = quarter_sine(COORD_W'(g << (16 - QB)));
    end

    logic [1:0]         w_quad;
    logic [QB-1:0]      w_rofs;
    logic [QB:0]        w_k;
    logic [SHAPE_W-1:0] w_sin;

    assign w_ordn = r_ord[i_cmd.axis*ORD_W +: ORD_W];
    assign w_tsum = 21'(w_ordn) * 21'(r_cu[i_cmd.axis]) + HALF;
    assign w_quad = r_sidx[SB-1 -: 2];
    assign w_rofs = r_sidx[QB-1:0];
    assign w_k    = w_quad[0] ? ((QB+1)'(QN) - {1'b0, w_rofs}) : {1'b0, w_rofs};
    assign w_sin  = w_rom[w_k];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat) begin
            r_ord   <= w_ord_q;
            r_gain  <= w_gain_q;
            r_amp   <= w_rd_amp;
            r_shape <= SHAPE_W'(16384);
            r_sneg  <= 1'b0;
        end else if (i_cmd.shp_step && r_sen) begin
            r_shape <= SHAPE_W'((30'(r_shape) * 30'(w_sin) + 30'd8192) >> 14);
            r_sneg  <= r_sneg ^ w_quad[1];
        end
        if (i_cmd.idx_calc) begin
            r_sidx <= w_tsum[17-SB +: SB];
            r_sen  <= (w_ordn != '0);
        end
    end

    // gain chain: gain*shape, times impulse*excitation gain, rounded / (10 * 2^34)
    logic [30:0] r_gs;
    logic [29:0] r_t;
    logic [26:0] r_delta;
    logic [63:0] w_prod;
    logic [61:0] w_recip;

    assign w_prod  = 64'(r_p1) * 64'(r_gs) + (64'd5 << 34);
    assign w_recip = 62'(r_t) * 62'(32'hCCCC_CCCD);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_gs) r_gs    <= 31'(r_gain) * 31'(r_shape);
        if (i_cmd.mul_p)  r_t     <= w_prod[63:34];
        if (i_cmd.mul_q)  r_delta <= w_recip[61:35];
    end

    // energy accumulator
    logic [EN_W-1:0] r_energy;

    // amplitude update with clamp
    logic signed [28:0] w_dlt, w_amp_sum;
    logic               w_hi, w_lo, w_sat;
    logic [EN_W-1:0]    w_abs, w_e_tot;

    assign w_dlt     = r_sneg ? -$signed({2'b00, r_delta}) : $signed({2'b00, r_delta});
    assign w_amp_sum = 29'(r_amp) + w_dlt;
    assign w_hi      = (w_amp_sum > LIM_P);
    assign w_lo      = (w_amp_sum < LIM_N);
    assign w_sat     = w_hi || w_lo;
    assign w_amp_new = w_hi ? LIM_P[AMP_W-1:0] :
                       w_lo ? LIM_N[AMP_W-1:0] : w_amp_sum[AMP_W-1:0];
    assign w_abs     = w_amp_new[AMP_W-1] ? EN_W'(-w_amp_new) : EN_W'(w_amp_new);
    assign w_e_tot   = r_energy + w_abs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_energy <= '0;
        end else if (i_cmd.sum_acc) begin
            r_energy <= r_energy + w_rd_abs;
        end else if (i_cmd.acc_upd) begin
            r_energy <= w_e_tot;
        end
    end

    // result register
    logic               r_out_vld;
    logic [IDX_W-1:0]   r_o_entry;
    logic [AMP_W-1:0]   r_o_amp;
    logic               r_o_sat;
    logic [EN_W-1:0]    r_o_energy;
    logic               r_o_silent;
    logic               r_o_last;

    assign o_stat.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.acc_upd || i_cmd.res_load || i_cmd.res_empty) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_upd) begin
            r_o_entry  <= IDX_W'(i_cmd.index);
            r_o_amp    <= w_amp_new;
            r_o_sat    <= w_sat;
            r_o_energy <= i_cmd.last ? w_e_tot : '0;
            r_o_silent <= i_cmd.last && (w_e_tot < r_floor);
            r_o_last   <= i_cmd.last;
        end else if (i_cmd.res_load) begin
            r_o_entry  <= r_mode_index;
            r_o_amp    <= '0;
            r_o_sat    <= 1'b0;
            r_o_energy <= r_energy;
            r_o_silent <= (r_energy < r_floor);
            r_o_last   <= 1'b1;
        end else if (i_cmd.res_empty) begin
            r_o_entry  <= '0;
            r_o_amp    <= '0;
            r_o_sat    <= 1'b0;
            r_o_energy <= '0;
            r_o_silent <= (r_floor != '0);
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_entry     = r_o_entry;
    assign o_amplitude = r_o_amp;
    assign o_saturated = r_o_sat;
    assign o_energy    = r_o_energy;
    assign o_silent    = r_o_silent;
    assign o_last      = r_o_last;

endmodule

// ----- rtl/core/modal_impact_excitation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modal_impact_excitation
// Modal table with impact excitation: load requests write one mode, impact
// requests add a shaped impulse to every walked mode's amplitude.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one request at a time (tuser = kind: load or impact).
//   Master stream returns one result per load, one per walked mode per impact;
//   tlast marks the final result, which alone carries energy and silent.
//   Config channel writes registers by index; the user must do so only while
//   the block is idle, as the block itself does not enforce it.
// Steps from acceptance to the last result entering the output reg:
//   load:   mode write, then an energy walk reading one amplitude at a time
//   impact: three restoring divisions for the contact point, then a pass
//           per mode on the shared sine/multiplier path
//   N is the walked mode count; an impact with N = 0 gives one result.
//   A new request is taken once the previous one has finished.
// Reset: synchronous, active low; config returns to defaults and all
//   amplitudes read as zero. Mode orders and gains are undefined until loaded.
// Stall: results wait in the output register; the sequencer holds while it
//   is full and not being taken.
// ----------------------------------------------------------------------------
module modal_impact_excitation #(
    parameter int MAX_MODES       = mie_pkg::MAX_MODES_DEF,
    parameter int SINE_TABLE_BITS = mie_pkg::SINE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] mode_index, [7:4] order_x, [11:8] order_y, [15:12] order_z,
    // [31:16] mode_gain, [47:32] impulse, [63:48] point_x, [79:64] point_y,
    // [95:80] point_z
    input  logic [95:0]                   s_axis_tdata,
    // [0] kind
    input  logic                          s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] entry, [19:4] amplitude, [20] saturated, [39:21] energy,
    // [40] silent, [47:41] zero
    output logic [47:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mie_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [mie_pkg::CFG_D_W-1:0]   i_cfg_data
);

    import mie_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_entry;
    logic [AMP_W-1:0] w_amp;
    logic             w_sat;
    logic [EN_W-1:0]  w_energy;
    logic             w_silent;

    assign o_cfg_ready = 1'b1;

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mie_dp #(
        .MAX_MODES       (MAX_MODES),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_mode_index (s_axis_tdata[3:0]),
        .i_orders     (s_axis_tdata[15:4]),
        .i_mode_gain  (s_axis_tdata[31:16]),
        .i_impulse    (s_axis_tdata[47:32]),
        .i_point_x    (s_axis_tdata[63:48]),
        .i_point_y    (s_axis_tdata[79:64]),
        .i_point_z    (s_axis_tdata[95:80]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_entry      (w_entry),
        .o_amplitude  (w_amp),
        .o_saturated  (w_sat),
        .o_energy     (w_energy),
        .o_silent     (w_silent),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, w_silent, w_energy, w_sat, w_amp, w_entry};

`ifndef NO_ASSERTIONS
    // a result is only produced into a free output register
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.acc_upd || w_cmd.res_load || w_cmd.res_empty) |-> w_stat.out_free)
        else $error("result written while output register busy");

    // at most one result source per cycle
    a_res_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.acc_upd, w_cmd.res_load, w_cmd.res_empty}))
        else $error("multiple result sources");

    // one request in flight: busy right after acceptance
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");
`endif

endmodule
